// ----- hdl/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants and controller/datapath interface types for the
// range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int LEAF_COUNT  = 1 << TREE_LEVELS;
  localparam int NODE_AW     = TREE_LEVELS + 1;
  localparam int POS_W       = 11;
  localparam int VAL_W       = 60;
  localparam int CW          = ((POS_W > NODE_AW) ? POS_W : NODE_AW) + 1;

  localparam logic [VAL_W-1:0] EMPTY_MIN = 60'd1000000000000000000;
  localparam logic [CW-1:0]    LEAF_CW   = CW'(LEAF_COUNT);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic q_left;
    logic q_right;
    logic q_shift;
    logic u_leaf;
    logic u_anc;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_query;
    logic in_upd_ok;
    logic lr_lt;
    logic u_top;
  } dp_stat_t;

endpackage

// ----- hdl/rmst_dp.sv -----
// ----------------------------------------------------------------------------
// rmst_dp
// Datapath: node store, query cursors, running minimum, update walker and
// result register.
// ----------------------------------------------------------------------------
module rmst_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rmst_pkg::dp_cmd_t           cmd,
  output rmst_pkg::dp_stat_t          stat,
  input  logic                        in_cmd,
  input  logic [rmst_pkg::POS_W-1:0]  in_left_pos,
  input  logic [rmst_pkg::POS_W-1:0]  in_right_end,
  input  logic [rmst_pkg::VAL_W-1:0]  in_new_value,
  output logic                        out_valid,
  output logic [rmst_pkg::VAL_W-1:0]  out_range_min
);

  logic [rmst_pkg::VAL_W-1:0]   mem [2**rmst_pkg::NODE_AW];

  logic [rmst_pkg::NODE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                         pend_r, pend_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rmst_pkg::VAL_W-1:0]   out_min_r, out_min_nxt;
  logic [rmst_pkg::CW-1:0]      l_r, l_nxt, r_r, r_nxt;
  logic [rmst_pkg::VAL_W-1:0]   res_r, res_nxt;
  logic [rmst_pkg::NODE_AW-1:0] node_r, node_nxt;
  logic [rmst_pkg::VAL_W-1:0]   cur_r, cur_nxt;
  logic [rmst_pkg::VAL_W-1:0]   rd_data_r;

  logic [rmst_pkg::NODE_AW-1:0] rd_addr, wr_addr, parent;
  logic                         wr_en;
  logic [rmst_pkg::VAL_W-1:0]   wr_data, anc_min, res_fold;
  logic [rmst_pkg::CW-1:0]      left_x, right_x, lc, rc, r_dec;
  logic                         full;

  assign left_x  = rmst_pkg::CW'(in_left_pos);
  assign right_x = rmst_pkg::CW'(in_right_end);
  assign lc      = (left_x == '0) ? rmst_pkg::CW'(1) : left_x;
  assign rc      = (right_x > rmst_pkg::LEAF_CW) ? rmst_pkg::LEAF_CW + rmst_pkg::CW'(1)
                                                  : right_x;
  assign full    = (left_x <= rmst_pkg::CW'(1)) && (right_x > rmst_pkg::LEAF_CW);
  assign parent  = node_r >> 1;
  assign anc_min = (rd_data_r < cur_r) ? rd_data_r : cur_r;
  assign r_dec   = r_r - rmst_pkg::CW'(1);
  assign res_fold = (pend_r && (rd_data_r < res_r)) ? rd_data_r : res_r;

  assign stat.clr_last  = (clr_cnt_r == '1);
  assign stat.in_query  = (in_cmd == rmst_pkg::CMD_QUERY);
  assign stat.in_upd_ok = (left_x != '0) && (left_x <= rmst_pkg::LEAF_CW);
  assign stat.lr_lt     = (l_r < r_r);
  assign stat.u_top     = (parent == rmst_pkg::NODE_AW'(1));

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_min_nxt   = out_min_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    res_nxt       = res_fold;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    rd_addr       = node_r ^ rmst_pkg::NODE_AW'(1);
    wr_en         = 1'b0;
    wr_addr       = node_r;
    wr_data       = cur_r;

    if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + rmst_pkg::NODE_AW'(1);
      wr_en       = 1'b1;
      wr_addr     = clr_cnt_r;
      wr_data     = '0;
    end

    if (cmd.load) begin
      if (full) begin
        l_nxt   = rmst_pkg::CW'(1);
        r_nxt   = rmst_pkg::CW'(2);
        res_nxt = '1;
      end else begin
        l_nxt   = lc + rmst_pkg::LEAF_CW - rmst_pkg::CW'(1);
        r_nxt   = rc + rmst_pkg::LEAF_CW - rmst_pkg::CW'(1);
        res_nxt = rmst_pkg::EMPTY_MIN;
      end
      node_nxt = rmst_pkg::NODE_AW'(left_x + rmst_pkg::LEAF_CW - rmst_pkg::CW'(1));
      cur_nxt  = in_new_value;
    end

    if (cmd.q_left && (l_r < r_r) && l_r[0]) begin
      rd_addr  = l_r[rmst_pkg::NODE_AW-1:0];
      pend_nxt = 1'b1;
      l_nxt    = l_r + rmst_pkg::CW'(1);
    end

    if (cmd.q_right && r_r[0]) begin
      rd_addr  = r_dec[rmst_pkg::NODE_AW-1:0];
      pend_nxt = 1'b1;
      r_nxt    = r_dec;
    end

    if (cmd.q_shift) begin
      l_nxt = l_r >> 1;
      r_nxt = r_r >> 1;
    end

    if (cmd.u_leaf) begin
      wr_en   = 1'b1;
      rd_addr = node_r ^ rmst_pkg::NODE_AW'(1);
    end

    if (cmd.u_anc) begin
      wr_en    = 1'b1;
      wr_addr  = parent;
      wr_data  = anc_min;
      cur_nxt  = anc_min;
      node_nxt = parent;
      rd_addr  = parent ^ rmst_pkg::NODE_AW'(1);
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_min_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_min_r <= out_min_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    res_r     <= res_nxt;
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_min = out_min_r;

endmodule

// ----- hdl/rmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmst_ctrl
// Controller: clearing pass, query level sequencing and update ancestor walk.
// ----------------------------------------------------------------------------
module rmst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rmst_pkg::dp_stat_t  stat,
  output rmst_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_Q_L,
    S_Q_R,
    S_Q_S,
    S_U_LEAF,
    S_U_ANC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.in_query) begin
            state_nxt = S_Q_L;
          end else if (stat.in_upd_ok) begin
            state_nxt = S_U_LEAF;
          end
        end
      end
      S_Q_L: begin
        if (stat.lr_lt) begin
          cmd.q_left = 1'b1;
          state_nxt  = S_Q_R;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_R: begin
        cmd.q_right = 1'b1;
        state_nxt   = S_Q_S;
      end
      S_Q_S: begin
        cmd.q_shift = 1'b1;
        state_nxt   = S_Q_L;
      end
      S_U_LEAF: begin
        cmd.u_leaf = 1'b1;
        state_nxt  = S_U_ANC;
      end
      S_U_ANC: begin
        cmd.u_anc = 1'b1;
        if (stat.u_top) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ----- hdl/range_min_segment_tree.sv -----
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Segment tree over positions 1..2^TREE_LEVELS: point update and half-open
// range minimum query, one command at a time.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | transfer
//  ---------+-----------------------------------------------+-------------------
//  command  | in_cmd, in_left_pos, in_right_end, in_new_value| start && !busy
//  result   | out_range_min                                 | out_valid (1 cycle)
//
//  Update: leaf write, then one ancestor per cycle up to the root.
//  Query: each visited level takes a left read, a right read and a shift; the
//  single read port of the node store sets this level step.
//  After reset the node store is cleared, with busy high. The result strobe
//  cannot be stalled; the result register lets the next command start in the
//  cycle the result is shown.
// ----------------------------------------------------------------------------
module range_min_segment_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [rmst_pkg::POS_W-1:0]  in_left_pos,
  input  logic [rmst_pkg::POS_W-1:0]  in_right_end,
  input  logic [rmst_pkg::VAL_W-1:0]  in_new_value,
  output logic                        out_valid,
  output logic [rmst_pkg::VAL_W-1:0]  out_range_min
);

  rmst_pkg::dp_cmd_t  cmd;
  rmst_pkg::dp_stat_t stat;

  rmst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rmst_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_left_pos   (in_left_pos),
    .in_right_end  (in_right_end),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_range_min (out_range_min)
  );

endmodule
